// ----- sv/asfs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the assembly source field splitter.
// No dependencies; every other file imports this package.
package asfs_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] RAW_HI_CR = 8'h8D;
	localparam logic [7:0] RAW_HI_LF = 8'h8A;

	localparam logic [6:0] CH_NUL    = 7'h00;
	localparam logic [6:0] CH_TAB    = 7'h09;
	localparam logic [6:0] CH_LF     = 7'h0A;
	localparam logic [6:0] CH_CR     = 7'h0D;
	localparam logic [6:0] CH_SPACE  = 7'h20;
	localparam logic [6:0] CH_DEL    = 7'h7F;
	localparam logic [6:0] CH_SEMI   = 7'h3B;
	localparam logic [6:0] CH_STAR   = 7'h2A;
	localparam logic [6:0] CH_SLASH  = 7'h2F;
	localparam logic [6:0] CH_SQUOTE = 7'h27;
	localparam logic [6:0] CH_DQUOTE = 7'h22;

	typedef enum logic [1:0] {
		TAG_LABEL   = 2'd0,
		TAG_OPCODE  = 2'd1,
		TAG_OPERAND = 2'd2,
		TAG_COMMENT = 2'd3
	} field_tag_t;

	typedef enum logic [3:0] {
		ST_START     = 4'd0,
		ST_LABEL     = 4'd1,
		ST_GAP_LAB   = 4'd2,
		ST_OPCODE    = 4'd3,
		ST_GAP_OP    = 4'd4,
		ST_OPERAND   = 4'd5,
		ST_GAP_ARG   = 4'd6,
		ST_COMMENT   = 4'd7,
		ST_QUOTED    = 4'd8,
		ST_GAP_NOLAB = 4'd9
	} split_state_t;

	// Normalized character or end-of-line marker, as held in the queue.
	typedef struct packed {
		logic       eol;
		logic [6:0] ch;
	} item_t;

	typedef struct packed {
		logic       eol;
		field_tag_t tag;
		logic [6:0] ch;
	} result_t;

endpackage

// ----- sv/asfs_front.sv -----
`timescale 1ns / 1ps
// Front end: normalizes each raw source byte and decides whether it is kept.
// Depends on asfs_pkg.
module asfs_front import asfs_pkg::*; (
	input  logic [7:0] raw_byte,
	output logic       keep,
	output item_t      item
);

	logic [6:0] c7;

	assign c7 = raw_byte[6:0];

	always_comb begin
		keep     = 1'b0;
		item.eol = 1'b0;
		item.ch  = c7;
		if (raw_byte == RAW_HI_CR) begin
			keep     = 1'b1;
			item.eol = 1'b1;
			item.ch  = CH_NUL;
		end else if (raw_byte == RAW_HI_LF || c7 == CH_CR) begin
			keep = 1'b0;
		end else if (c7 == CH_LF) begin
			keep     = 1'b1;
			item.eol = 1'b1;
			item.ch  = CH_NUL;
		end else if (c7 == CH_TAB) begin
			keep    = 1'b1;
			item.ch = CH_SPACE;
		end else if (c7 >= CH_SPACE && c7 != CH_DEL) begin
			keep = 1'b1;
		end
	end

endmodule

// ----- sv/asfs_queue.sv -----
`timescale 1ns / 1ps
// Small FIFO between the front end and the splitter.
// Depends on asfs_pkg for the item type and depth.
module asfs_queue import asfs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output item_t head
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- sv/asfs_back.sv -----
`timescale 1ns / 1ps
// Back end: the field splitter state machine and the result register.
// Depends on asfs_pkg.
module asfs_back import asfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  item_t      head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] char_out,
	output logic [1:0] field_tag,
	output logic       end_of_line
);

	split_state_t state_q, state_d;
	logic [6:0]   delim_q, delim_d;
	logic         emit;
	field_tag_t   tag;
	logic         space;
	logic         is_semi;
	logic         is_star_slash;
	logic         is_quote;
	logic         out_valid_q;
	result_t      res_q;

	assign space         = (head.ch == CH_SPACE);
	assign is_semi       = (head.ch == CH_SEMI);
	assign is_star_slash = (head.ch == CH_STAR) || (head.ch == CH_SLASH);
	assign is_quote      = (head.ch == CH_SQUOTE) || (head.ch == CH_DQUOTE);

	// An item leaves the queue whenever the result register is free or being emptied.
	assign pop = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		delim_d = delim_q;
		if (head.eol) begin
			state_d = ST_START;
			delim_d = CH_NUL;
		end else begin
			unique case (state_q)
				ST_LABEL: begin
					if (space) state_d = ST_GAP_LAB;
				end
				ST_GAP_LAB, ST_GAP_NOLAB: begin
					if (is_semi || (is_star_slash && state_q == ST_GAP_NOLAB)) begin
						state_d = ST_COMMENT;
					end else if (!space) begin
						state_d = ST_OPCODE;
					end
				end
				ST_OPCODE: begin
					if (space) state_d = ST_GAP_OP;
				end
				ST_GAP_OP: begin
					if (is_semi) begin
						state_d = ST_COMMENT;
					end else if (head.ch == CH_SQUOTE) begin
						// Only a single quote opens quoted text as the first operand character.
						state_d = ST_QUOTED;
						delim_d = head.ch;
					end else if (!space) begin
						state_d = ST_OPERAND;
					end
				end
				ST_OPERAND: begin
					if (is_quote) begin
						state_d = ST_QUOTED;
						delim_d = head.ch;
					end else if (space) begin
						state_d = ST_GAP_ARG;
					end
				end
				ST_GAP_ARG: begin
					if (!space) state_d = ST_COMMENT;
				end
				ST_COMMENT: begin
					state_d = ST_COMMENT;
				end
				ST_QUOTED: begin
					if (head.ch == delim_q) state_d = ST_OPERAND;
				end
				default: begin
					if (is_semi || is_star_slash) begin
						state_d = ST_COMMENT;
					end else if (!space) begin
						state_d = ST_LABEL;
					end else begin
						state_d = ST_GAP_NOLAB;
					end
				end
			endcase
		end
	end

	always_comb begin
		emit = 1'b0;
		tag  = TAG_LABEL;
		if (head.eol) begin
			emit = 1'b1;
		end else begin
			unique case (state_q)
				ST_LABEL: begin
					emit = !space;
					tag  = TAG_LABEL;
				end
				ST_GAP_LAB, ST_GAP_NOLAB: begin
					if (is_semi || (is_star_slash && state_q == ST_GAP_NOLAB)) begin
						emit = 1'b1;
						tag  = TAG_COMMENT;
					end else begin
						emit = !space;
						tag  = TAG_OPCODE;
					end
				end
				ST_OPCODE: begin
					emit = !space;
					tag  = TAG_OPCODE;
				end
				ST_GAP_OP: begin
					emit = !space;
					tag  = is_semi ? TAG_COMMENT : TAG_OPERAND;
				end
				ST_OPERAND: begin
					emit = !space;
					tag  = TAG_OPERAND;
				end
				ST_GAP_ARG: begin
					emit = !space;
					tag  = TAG_COMMENT;
				end
				ST_COMMENT: begin
					emit = 1'b1;
					tag  = TAG_COMMENT;
				end
				ST_QUOTED: begin
					emit = 1'b1;
					tag  = TAG_OPERAND;
				end
				default: begin
					emit = !space;
					tag  = (is_semi || is_star_slash) ? TAG_COMMENT : TAG_LABEL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			delim_q     <= CH_NUL;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				state_q     <= state_d;
				delim_q     <= delim_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q.eol <= head.eol;
			res_q.tag <= tag;
			res_q.ch  <= head.ch;
		end
	end

	assign out_valid   = out_valid_q;
	assign char_out    = res_q.ch;
	assign field_tag   = res_q.tag;
	assign end_of_line = res_q.eol;

endmodule

// ----- sv/assembly_source_field_splitter_core.sv -----
`timescale 1ns / 1ps
// Assembly source field splitter: takes one raw source byte per cycle, while
// in_ready is high, and delivers each kept character tagged as label, opcode,
// operand or comment, plus an end-of-line item for each 8'h0A or 8'h8D byte.
// Sustained rate is one byte per cycle while the output is not stalled. A
// byte is normalized into a four-entry queue at the accepting edge, and the
// splitter state machine, which handles one queued byte a cycle while its
// output register is free or being emptied, steps it into that register.
// Dropped bytes and separating spaces produce no output item. The queue
// absorbs output stalls of up to four bytes before in_ready falls.
// Depends on asfs_pkg, asfs_front, asfs_queue and asfs_back.
module assembly_source_field_splitter_core import asfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] raw_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] char_out,
	output logic [1:0] field_tag,
	output logic       end_of_line
);

	logic  keep;
	item_t front_item;
	logic  q_full;
	logic  q_empty;
	item_t q_head;
	logic  q_pop;

	asfs_front u_front (
		.raw_byte (raw_byte),
		.keep     (keep),
		.item     (front_item)
	);

	asfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && keep),
		.push_item (front_item),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	asfs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (!q_empty),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_out    (char_out),
		.field_tag   (field_tag),
		.end_of_line (end_of_line)
	);

	assign in_ready = !q_full;

endmodule

// ----- sv/asfs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the field splitter top level, attached by bind.
// Depends on asfs_pkg and assembly_source_field_splitter_core.
module asfs_checker import asfs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] raw_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] char_out,
	input logic [1:0] field_tag,
	input logic       end_of_line
);

	// An end-of-line item carries no character and the label tag.
	a_eol_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_line |-> char_out == CH_NUL && field_tag == TAG_LABEL)
		else $error("end-of-line item carries a character or tag");

	// Every character item is printable after normalization.
	a_char_printable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_line |-> char_out >= CH_SPACE && char_out != CH_DEL)
		else $error("non-printable character item");

	// A line feed accepted while the queue has drained and the output register is free
	// passes through the queue and the output register and comes out as an end-of-line item.
	a_lf_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && raw_byte == {1'b0, CH_LF} && !out_valid && out_ready
		&& $past(!in_valid && !out_valid) && $past(!in_valid && !out_valid, 2)
		&& $past(!in_valid && !out_valid, 3) && $past(!in_valid && !out_valid, 4)
		|=> ##1 out_valid && end_of_line)
		else $error("line feed did not produce an end-of-line item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_out)
		&& $stable(field_tag) && $stable(end_of_line))
		else $error("stalled output item changed");

endmodule

bind assembly_source_field_splitter_core asfs_checker u_asfs_checker (.*);
